FILE: rtl/plvs_pkg.sv
// Types and constants shared by the point-light vertex shader.
// Used by plvs_root_div and point_light_vertex_shader_core; no dependencies.
package plvs_pkg;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_LIGHT_X      = 3'd0;
    localparam logic [2:0] REG_LIGHT_Y      = 3'd1;
    localparam logic [2:0] REG_LIGHT_Z      = 3'd2;
    localparam logic [2:0] REG_LIGHT_RADIUS = 3'd3;
    localparam logic [2:0] REG_LIGHT_RED    = 3'd4;
    localparam logic [2:0] REG_LIGHT_GREEN  = 3'd5;
    localparam logic [2:0] REG_LIGHT_BLUE   = 3'd6;
    localparam logic [2:0] REG_LIGHT_ALPHA  = 3'd7;

    // Pipeline geometry
    localparam int ROOT_BITS = 31;   // bits of the vector length
    localparam int QUOT_BITS = 20;   // quotient bits of both divides
    localparam int DIVN_BITS = 51;   // dividend width of both divides

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               has_normal;
        logic [15:0]        in_red;
        logic [15:0]        in_green;
        logic [15:0]        in_blue;
        logic [15:0]        in_alpha;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
        logic        in_range;
    } out_item_t;

    // Side data that rides along the root and divide stages
    typedef struct packed {
        logic [3:0][15:0] col;
        logic             lit;
        logic             has_normal;
        logic             ang_ok;
    } side_t;

endpackage

FILE: rtl/plvs_root_div.sv
// Pipelined square root (one result bit per stage) followed by two pipelined
// restoring divides sharing stage timing. Depends on plvs_pkg.
module plvs_root_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vld_in,
    input  logic [61:0]           sum_sq,
    input  logic signed [49:0]    dot,
    input  plvs_pkg::side_t       side_in,
    input  logic [30:0]           radius,
    output logic                  vld_out,
    output logic [plvs_pkg::QUOT_BITS-1:0] dist_q,
    output logic [plvs_pkg::QUOT_BITS-1:0] ang_q,
    output plvs_pkg::side_t       side_out
);

    localparam int RB = plvs_pkg::ROOT_BITS;
    localparam int QB = plvs_pkg::QUOT_BITS;
    localparam int NB = plvs_pkg::DIVN_BITS;

    logic [61:0]             sq_rem_reg  [1:RB];
    logic [RB-1:0]           sq_root_reg [1:RB];
    logic signed [49:0]      sq_dot_reg  [1:RB];
    plvs_pkg::side_t         sq_side_reg [1:RB];
    logic                    sq_vld_reg  [1:RB];

    logic [NB-1:0]           dv_ra_reg   [1:QB];
    logic [NB-1:0]           dv_rd_reg   [1:QB];
    logic [QB-1:0]           dv_qa_reg   [1:QB];
    logic [QB-1:0]           dv_qd_reg   [1:QB];
    logic [RB-1:0]           dv_len_reg  [1:QB];
    plvs_pkg::side_t         dv_side_reg [1:QB];
    logic                    dv_vld_reg  [1:QB];

    genvar k;

    // Square root: stage k decides bit RB-1-k
    generate
        for (k = 0; k < RB; k++) begin : g_root
            localparam int B = RB - 1 - k;
            logic [61:0]        rem_c;
            logic [RB-1:0]      root_c;
            logic signed [49:0] dot_c;
            plvs_pkg::side_t    side_c;
            logic               vld_c;
            logic [62:0]        trial;
            logic               take;
            logic [61:0]        rem_next;
            logic [RB-1:0]      root_next;

            if (k == 0) begin : g_first
                assign rem_c  = sum_sq;
                assign root_c = '0;
                assign dot_c  = dot;
                assign side_c = side_in;
                assign vld_c  = vld_in;
            end
            else begin : g_rest
                assign rem_c  = sq_rem_reg[k];
                assign root_c = sq_root_reg[k];
                assign dot_c  = sq_dot_reg[k];
                assign side_c = sq_side_reg[k];
                assign vld_c  = sq_vld_reg[k];
            end

            assign trial     = (63'(root_c) << (B + 1)) | (63'(1) << (2 * B));
            assign take      = {1'b0, rem_c} >= trial;
            assign rem_next  = take ? 62'({1'b0, rem_c} - trial) : rem_c;
            assign root_next = take ? (root_c | (RB'(1) << B)) : root_c;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_vld_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    sq_vld_reg[k+1] <= vld_c;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[k+1]  <= rem_next;
                    sq_root_reg[k+1] <= root_next;
                    sq_dot_reg[k+1]  <= dot_c;
                    sq_side_reg[k+1] <= side_c;
                end
            end
        end
    endgenerate

    // Divides: 4*dot / len for the angle, (len << 16) / radius for distance
    generate
        for (k = 0; k < QB; k++) begin : g_div
            localparam int B = QB - 1 - k;
            logic [NB-1:0]   ra_c;
            logic [NB-1:0]   rd_c;
            logic [QB-1:0]   qa_c;
            logic [QB-1:0]   qd_c;
            logic [RB-1:0]   len_c;
            plvs_pkg::side_t side_c;
            logic            vld_c;
            logic [NB-1:0]   sub_a;
            logic [NB-1:0]   sub_d;
            logic            take_a;
            logic            take_d;

            if (k == 0) begin : g_first
                logic dot_pos;
                assign dot_pos = (sq_dot_reg[RB] > 50'sd0);
                assign len_c   = sq_root_reg[RB];
                assign ra_c    = dot_pos ? {sq_dot_reg[RB][48:0], 2'b00} : '0;
                assign rd_c    = {4'b0, sq_root_reg[RB], 16'b0};
                assign qa_c    = '0;
                assign qd_c    = '0;
                assign vld_c   = sq_vld_reg[RB];
                always_comb
                begin
                    side_c        = sq_side_reg[RB];
                    side_c.ang_ok = sq_side_reg[RB].has_normal && dot_pos
                                    && (sq_root_reg[RB] != '0);
                end
            end
            else begin : g_rest
                assign ra_c   = dv_ra_reg[k];
                assign rd_c   = dv_rd_reg[k];
                assign qa_c   = dv_qa_reg[k];
                assign qd_c   = dv_qd_reg[k];
                assign len_c  = dv_len_reg[k];
                assign side_c = dv_side_reg[k];
                assign vld_c  = dv_vld_reg[k];
            end

            assign sub_a  = NB'(len_c) << B;
            assign sub_d  = NB'(radius) << B;
            assign take_a = ra_c >= sub_a;
            assign take_d = rd_c >= sub_d;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_vld_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    dv_vld_reg[k+1] <= vld_c;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_ra_reg[k+1]   <= take_a ? ra_c - sub_a : ra_c;
                    dv_rd_reg[k+1]   <= take_d ? rd_c - sub_d : rd_c;
                    dv_qa_reg[k+1]   <= take_a ? (qa_c | (QB'(1) << B)) : qa_c;
                    dv_qd_reg[k+1]   <= take_d ? (qd_c | (QB'(1) << B)) : qd_c;
                    dv_len_reg[k+1]  <= len_c;
                    dv_side_reg[k+1] <= side_c;
                end
            end
        end
    endgenerate

    assign vld_out  = dv_vld_reg[QB];
    assign dist_q   = dv_qd_reg[QB];
    assign ang_q    = dv_qa_reg[QB];
    assign side_out = dv_side_reg[QB];

endmodule

FILE: rtl/point_light_vertex_shader_core.sv
// Point-light vertex shader: one vertex in, one lit colour out.
// Pipeline: 3 front stages, 31 root stages, 20 divide stages, 6 back.
// Throughput one item per clock; the whole pipeline holds while the output
// item waits under stall. Reset clears valid bits and loads the light registers.
// Depends on plvs_pkg and plvs_root_div.
module point_light_vertex_shader_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  plvs_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output plvs_pkg::out_item_t out_item
);

    localparam int QB = plvs_pkg::QUOT_BITS;

    logic signed [31:0] light_x_reg, light_y_reg, light_z_reg;
    logic [30:0]        light_radius_reg;
    logic [3:0][15:0]   light_col_reg;

    logic en;
    logic cfg_wr;

    // Front stage 1: differences and magnitudes
    logic               f1_vld_reg;
    logic [30:0]        f1_mag_reg [3];
    logic signed [31:0] f1_dif_reg [3];
    logic signed [15:0] f1_nrm_reg [3];
    logic               f1_far_reg;
    logic               f1_hasn_reg;
    logic [3:0][15:0]   f1_col_reg;

    // Front stage 2: squares and products
    logic               f2_vld_reg;
    logic [61:0]        f2_sq_reg [3];
    logic signed [47:0] f2_prod_reg [3];
    logic [61:0]        f2_rr_reg;
    logic               f2_far_reg;
    logic               f2_hasn_reg;
    logic [3:0][15:0]   f2_col_reg;

    // Front stage 3: sums and range test
    logic               f3_vld_reg;
    logic [61:0]        f3_sum_reg;
    logic signed [49:0] f3_dot_reg;
    plvs_pkg::side_t    f3_side_reg;

    logic               rd_vld;
    logic [QB-1:0]      rd_dist_q;
    logic [QB-1:0]      rd_ang_q;
    plvs_pkg::side_t    rd_side;

    // Back stages
    logic               e1_vld_reg, e2_vld_reg, e3_vld_reg, e4_vld_reg, e5_vld_reg;
    logic [16:0]        e1_f_reg, e2_f_reg;
    logic [21:0]        e1_ang_reg, e2_ang_reg, e3_ang_reg;
    plvs_pkg::side_t    e1_side_reg, e2_side_reg, e3_side_reg, e4_side_reg, e5_side_reg;
    logic [16:0]        e2_ff_reg;
    logic [16:0]        e3_f3_reg;
    logic [23:0]        e4_k_reg;
    logic [3:0][23:0]   e5_add_reg;
    logic               out_valid_reg;
    plvs_pkg::out_item_t out_item_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg      <= '0;
            light_y_reg      <= '0;
            light_z_reg      <= '0;
            light_radius_reg <= 31'd655360;
            light_col_reg    <= {4{16'd4096}};
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                plvs_pkg::REG_LIGHT_X:      light_x_reg      <= pwdata;
                plvs_pkg::REG_LIGHT_Y:      light_y_reg      <= pwdata;
                plvs_pkg::REG_LIGHT_Z:      light_z_reg      <= pwdata;
                plvs_pkg::REG_LIGHT_RADIUS: light_radius_reg <= pwdata[30:0];
                plvs_pkg::REG_LIGHT_RED:    light_col_reg[3] <= pwdata[15:0];
                plvs_pkg::REG_LIGHT_GREEN:  light_col_reg[2] <= pwdata[15:0];
                plvs_pkg::REG_LIGHT_BLUE:   light_col_reg[1] <= pwdata[15:0];
                plvs_pkg::REG_LIGHT_ALPHA:  light_col_reg[0] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            plvs_pkg::REG_LIGHT_X:      prdata = light_x_reg;
            plvs_pkg::REG_LIGHT_Y:      prdata = light_y_reg;
            plvs_pkg::REG_LIGHT_Z:      prdata = light_z_reg;
            plvs_pkg::REG_LIGHT_RADIUS: prdata = {1'b0, light_radius_reg};
            plvs_pkg::REG_LIGHT_RED:    prdata = {16'b0, light_col_reg[3]};
            plvs_pkg::REG_LIGHT_GREEN:  prdata = {16'b0, light_col_reg[2]};
            plvs_pkg::REG_LIGHT_BLUE:   prdata = {16'b0, light_col_reg[1]};
            plvs_pkg::REG_LIGHT_ALPHA:  prdata = {16'b0, light_col_reg[0]};
            default:                    prdata = '0;
        endcase
    end

    // Front stage 1
    logic signed [32:0] dif_next [3];
    logic [32:0]        mag_next [3];
    logic               far_next;

    always_comb
    begin
        dif_next[0] = 33'(light_x_reg) - 33'(in_item.vertex_x);
        dif_next[1] = 33'(light_y_reg) - 33'(in_item.vertex_y);
        dif_next[2] = 33'(light_z_reg) - 33'(in_item.vertex_z);
        far_next    = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = dif_next[i][32] ? 33'(-dif_next[i]) : 33'(dif_next[i]);
            far_next    = far_next | (mag_next[i][32:31] != 2'b00);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg    <= 1'b0;
            f2_vld_reg    <= 1'b0;
            f3_vld_reg    <= 1'b0;
            e1_vld_reg    <= 1'b0;
            e2_vld_reg    <= 1'b0;
            e3_vld_reg    <= 1'b0;
            e4_vld_reg    <= 1'b0;
            e5_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_vld_reg    <= in_valid;
            f2_vld_reg    <= f1_vld_reg;
            f3_vld_reg    <= f2_vld_reg;
            e1_vld_reg    <= rd_vld;
            e2_vld_reg    <= e1_vld_reg;
            e3_vld_reg    <= e2_vld_reg;
            e4_vld_reg    <= e3_vld_reg;
            e5_vld_reg    <= e4_vld_reg;
            out_valid_reg <= e5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                f1_mag_reg[i] <= mag_next[i][30:0];
                f1_dif_reg[i] <= dif_next[i][31:0];
            end
            f1_nrm_reg[0] <= in_item.normal_x;
            f1_nrm_reg[1] <= in_item.normal_y;
            f1_nrm_reg[2] <= in_item.normal_z;
            f1_far_reg    <= far_next;
            f1_hasn_reg   <= in_item.has_normal;
            f1_col_reg    <= {in_item.in_red, in_item.in_green,
                              in_item.in_blue, in_item.in_alpha};
        end
    end

    // Front stage 2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                f2_sq_reg[i]   <= 62'(f1_mag_reg[i]) * 62'(f1_mag_reg[i]);
                f2_prod_reg[i] <= 48'(f1_dif_reg[i]) * 48'(f1_nrm_reg[i]);
            end
            f2_rr_reg   <= 62'(light_radius_reg) * 62'(light_radius_reg);
            f2_far_reg  <= f1_far_reg;
            f2_hasn_reg <= f1_hasn_reg;
            f2_col_reg  <= f1_col_reg;
        end
    end

    // Front stage 3
    logic [63:0]     sum_next;
    plvs_pkg::side_t side_next;

    always_comb
    begin
        sum_next             = 64'(f2_sq_reg[0]) + 64'(f2_sq_reg[1]) + 64'(f2_sq_reg[2]);
        side_next.col        = f2_col_reg;
        side_next.has_normal = f2_hasn_reg;
        side_next.ang_ok     = 1'b0;
        side_next.lit        = !f2_far_reg && (light_radius_reg != '0)
                               && (sum_next <= 64'(f2_rr_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f3_sum_reg  <= sum_next[61:0];
            f3_dot_reg  <= 50'(f2_prod_reg[0]) + 50'(f2_prod_reg[1])
                           + 50'(f2_prod_reg[2]);
            f3_side_reg <= side_next;
        end
    end

    plvs_root_div u_root_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (f3_vld_reg),
        .sum_sq   (f3_sum_reg),
        .dot      (f3_dot_reg),
        .side_in  (f3_side_reg),
        .radius   (light_radius_reg),
        .vld_out  (rd_vld),
        .dist_q   (rd_dist_q),
        .ang_q    (rd_ang_q),
        .side_out (rd_side)
    );

    // Back stages: falloff cube, factor product, light scaling, saturation
    logic [21:0]      ang_next;
    logic [18:0]      fall_next;
    logic [3:0][24:0] col_sum;
    plvs_pkg::out_item_t out_next;

    always_comb
    begin
        if (!rd_side.has_normal)
            ang_next = 22'd65536;
        else if (rd_side.ang_ok)
            ang_next = 22'(rd_ang_q) * 22'd3;
        else
            ang_next = '0;
        fall_next = 19'(e3_f3_reg) * 19'd3;
        for (int c = 0; c < 4; c++)
            col_sum[c] = 25'(e5_side_reg.col[c]) + 25'(e5_add_reg[c]);
        out_next.in_range = e5_side_reg.lit;
        out_next.out_red   = e5_side_reg.col[3];
        out_next.out_green = e5_side_reg.col[2];
        out_next.out_blue  = e5_side_reg.col[1];
        out_next.out_alpha = e5_side_reg.col[0];
        if (e5_side_reg.lit)
        begin
            out_next.out_red   = (col_sum[3] > 25'd65535) ? 16'hFFFF : col_sum[3][15:0];
            out_next.out_green = (col_sum[2] > 25'd65535) ? 16'hFFFF : col_sum[2][15:0];
            out_next.out_blue  = (col_sum[1] > 25'd65535) ? 16'hFFFF : col_sum[1][15:0];
            out_next.out_alpha = (col_sum[0] > 25'd65535) ? 16'hFFFF : col_sum[0][15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_f_reg    <= 17'd65536 - rd_dist_q[16:0];
            e1_ang_reg  <= ang_next;
            e1_side_reg <= rd_side;

            e2_ff_reg   <= 17'((34'(e1_f_reg) * 34'(e1_f_reg)) >> 16);
            e2_f_reg    <= e1_f_reg;
            e2_ang_reg  <= e1_ang_reg;
            e2_side_reg <= e1_side_reg;

            e3_f3_reg   <= 17'((34'(e2_ff_reg) * 34'(e2_f_reg)) >> 16);
            e3_ang_reg  <= e2_ang_reg;
            e3_side_reg <= e2_side_reg;

            e4_k_reg    <= 24'((41'(fall_next) * 41'(e3_ang_reg)) >> 16);
            e4_side_reg <= e3_side_reg;

            for (int c = 0; c < 4; c++)
                e5_add_reg[c] <= 24'((40'(light_col_reg[c]) * 40'(e4_k_reg)) >> 16);
            e5_side_reg <= e4_side_reg;

            out_item_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Only a held output item may stall the input side
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held output item");

    // A lit vertex never lies beyond the radius
    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld && rd_side.lit) |-> (rd_dist_q <= 20'd65536))
        else $error("distance quotient above one");

    // Back stage valids hold while stalled
    a_hold_back: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({e1_vld_reg, e2_vld_reg, e3_vld_reg, e4_vld_reg, e5_vld_reg}))
        else $error("back stage valid moved under stall");

    // An unlit item leaves with its colour untouched (checked on the red channel)
    a_unlit_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (en && e5_vld_reg && !e5_side_reg.lit) |=>
            (out_item.out_red == $past(e5_side_reg.col[3])))
        else $error("unlit item colour changed");

endmodule
